// ===== hw/rtl/rfas_pkg.sv =====
package rfas_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_CHAN   = 2'd1,
        OP_BUTTON = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CFG_ALERT_THRESHOLD = 2'd0,
        CFG_SWEEP_PERIOD    = 2'd1,
        CFG_PEEK_DURATION   = 2'd2
    } t_cfg_idx;

    localparam logic [7:0]  THRESHOLD_RESET = 8'd10;
    localparam logic [7:0]  PERIOD_RESET    = 8'd10;
    localparam logic [15:0] PEEK_RESET_MS   = 16'd5000;
    localparam logic [14:0] TICK_UNIT_MS    = 15'd100;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

    // x / 1000 == (x * DIV1000_MAGIC) >> DIV1000_SHIFT for every 32-bit x
    localparam logic [28:0] DIV1000_MAGIC = 29'h10624DD3;
    localparam int          DIV1000_SHIFT = 38;
    localparam int          PROD_W        = 61;

    typedef struct packed {
        logic        sweep_request;
        logic        alert_active;
        logic        screen_dark;
        logic [15:0] alert_count;
        logic [15:0] sweep_count;
        logic [15:0] alert_mhz;
        logic [7:0]  alert_margin_db;
        logic        age_en;
        logic [31:0] age_ms;
    } t_stat;

endpackage

// ===== hw/rtl/rfas_req_if.sv =====
interface rfas_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] now_ms;
    logic [7:0]  peak_strength;
    logic        peak_valid;
    logic [7:0]  floor_level;
    logic [15:0] channel_mhz;
    logic        last_channel;

    modport source (
        output valid, operation, now_ms, peak_strength, peak_valid, floor_level,
               channel_mhz, last_channel,
        input  ready
    );

    modport sink (
        input  valid, operation, now_ms, peak_strength, peak_valid, floor_level,
               channel_mhz, last_channel,
        output ready
    );
endinterface

// ===== hw/rtl/rfas_rsp_if.sv =====
interface rfas_rsp_if;
    logic        valid;
    logic        ready;
    logic        sweep_request;
    logic        alert_active;
    logic        screen_dark;
    logic [15:0] alert_count;
    logic [15:0] sweep_count;
    logic [15:0] alert_mhz;
    logic [7:0]  alert_margin_db;
    logic [22:0] alert_age_s;

    modport source (
        output valid, sweep_request, alert_active, screen_dark, alert_count,
               sweep_count, alert_mhz, alert_margin_db, alert_age_s,
        input  ready
    );

    modport sink (
        input  valid, sweep_request, alert_active, screen_dark, alert_count,
               sweep_count, alert_mhz, alert_margin_db, alert_age_s,
        output ready
    );
endinterface

// ===== hw/rtl/rfas_state.sv =====
module rfas_state (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    rfas_req_if.sink           i_req,
    output rfas_pkg::t_stat    o_stat,
    output logic               o_stat_valid,
    input  logic               i_stat_ready
);
    import rfas_pkg::*;

    logic [7:0]  r_thresh;
    logic [7:0]  r_period;
    logic [15:0] r_peek_dur;

    logic [31:0] r_sweep_start, n_sweep_start;
    logic [31:0] r_peek_until,  n_peek_until;
    logic        r_alert,       n_alert;
    logic        r_dark,        n_dark;
    logic [7:0]  r_best_margin, n_best_margin;
    logic [15:0] r_best_mhz,    n_best_mhz;
    logic [15:0] r_alerts,      n_alerts;
    logic [15:0] r_sweeps,      n_sweeps;
    logic [15:0] r_rec_mhz,     n_rec_mhz;
    logic [7:0]  r_rec_margin,  n_rec_margin;
    logic [31:0] r_alert_time,  n_alert_time;

    t_stat       r_stat, n_stat;
    logic        r_stat_valid;

    logic        accept;
    logic [31:0] elapsed;
    logic [14:0] sweep_gap;
    logic [31:0] peek_left;
    logic        tick_dark;
    logic        margin_ok;
    logic [7:0]  margin;
    logic [7:0]  cand_margin;
    logic [15:0] cand_mhz;
    logic [31:0] age_now;
    logic        req;

    assign i_req.ready  = !r_stat_valid || i_stat_ready;
    assign accept       = i_req.valid && i_req.ready;
    assign o_stat       = r_stat;
    assign o_stat_valid = r_stat_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh   <= THRESHOLD_RESET;
            r_period   <= PERIOD_RESET;
            r_peek_dur <= PEEK_RESET_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALERT_THRESHOLD: r_thresh   <= i_cfg_wdata[7:0];
                CFG_SWEEP_PERIOD:    r_period   <= i_cfg_wdata[7:0];
                CFG_PEEK_DURATION:   r_peek_dur <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign sweep_gap   = 15'(r_period) * TICK_UNIT_MS;
    assign elapsed     = i_req.now_ms - r_sweep_start;
    assign peek_left   = r_peek_until - i_req.now_ms;
    assign tick_dark   = !((peek_left != 32'd0) && !peek_left[31]);
    assign margin_ok   = i_req.peak_valid && (i_req.floor_level > i_req.peak_strength);
    assign margin      = i_req.floor_level - i_req.peak_strength;
    assign cand_margin = (margin_ok && margin > r_best_margin) ? margin : r_best_margin;
    assign cand_mhz    = (margin_ok && margin > r_best_margin) ? i_req.channel_mhz
                                                                : r_best_mhz;

    always_comb begin
        n_sweep_start = r_sweep_start;
        n_peek_until  = r_peek_until;
        n_alert       = r_alert;
        n_dark        = r_dark;
        n_best_margin = r_best_margin;
        n_best_mhz    = r_best_mhz;
        n_alerts      = r_alerts;
        n_sweeps      = r_sweeps;
        n_rec_mhz     = r_rec_mhz;
        n_rec_margin  = r_rec_margin;
        n_alert_time  = r_alert_time;
        age_now       = i_req.now_ms;
        req           = 1'b0;

        unique case (i_req.operation)
            OP_TICK: begin
                if (elapsed >= 32'(sweep_gap)) begin
                    n_sweep_start = i_req.now_ms;
                    n_sweeps      = (r_sweeps == COUNT_MAX) ? COUNT_MAX : r_sweeps + 16'd1;
                    n_best_margin = 8'd0;
                    n_best_mhz    = 16'd0;
                    req           = 1'b1;
                end
                if (!r_alert) begin
                    n_dark = tick_dark;
                end
            end
            OP_CHAN: begin
                n_best_margin = cand_margin;
                n_best_mhz    = cand_mhz;
                if (i_req.last_channel) begin
                    if (cand_margin != 8'd0 && cand_margin >= r_thresh) begin
                        n_alerts     = (r_alerts == COUNT_MAX) ? COUNT_MAX : r_alerts + 16'd1;
                        n_rec_mhz    = cand_mhz;
                        n_rec_margin = cand_margin;
                        n_alert_time = r_sweep_start;
                        n_alert      = 1'b1;
                        n_dark       = 1'b0;
                    end
                    n_best_margin = 8'd0;
                    n_best_mhz    = 16'd0;
                end
                age_now = r_sweep_start;
            end
            OP_BUTTON: begin
                // remaining peek time right after the press equals the duration
                n_alert      = 1'b0;
                n_peek_until = i_req.now_ms + 32'(r_peek_dur);
                n_dark       = (r_peek_dur == 16'd0);
            end
            default: ;
        endcase

        n_stat.sweep_request   = req;
        n_stat.alert_active    = n_alert;
        n_stat.screen_dark     = n_dark;
        n_stat.alert_count     = n_alerts;
        n_stat.sweep_count     = n_sweeps;
        n_stat.alert_mhz       = n_rec_mhz;
        n_stat.alert_margin_db = n_rec_margin;
        n_stat.age_en          = (n_rec_mhz != 16'd0);
        n_stat.age_ms          = age_now - n_alert_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_start <= 32'd0;
            r_peek_until  <= 32'(PEEK_RESET_MS);
            r_alert       <= 1'b0;
            r_dark        <= 1'b0;
            r_best_margin <= 8'd0;
            r_best_mhz    <= 16'd0;
            r_alerts      <= 16'd0;
            r_sweeps      <= 16'd0;
            r_rec_mhz     <= 16'd0;
            r_rec_margin  <= 8'd0;
            r_alert_time  <= 32'd0;
            r_stat_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_sweep_start <= n_sweep_start;
                r_peek_until  <= n_peek_until;
                r_alert       <= n_alert;
                r_dark        <= n_dark;
                r_best_margin <= n_best_margin;
                r_best_mhz    <= n_best_mhz;
                r_alerts      <= n_alerts;
                r_sweeps      <= n_sweeps;
                r_rec_mhz     <= n_rec_mhz;
                r_rec_margin  <= n_rec_margin;
                r_alert_time  <= n_alert_time;
                r_stat_valid  <= 1'b1;
            end else if (i_stat_ready) begin
                r_stat_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stat <= n_stat;
        end
    end

endmodule

// ===== hw/rtl/rfas_age.sv =====
module rfas_age (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rfas_pkg::t_stat    i_stat,
    input  logic               i_stat_valid,
    output logic               o_stat_ready,
    rfas_rsp_if.source         o_rsp
);
    import rfas_pkg::*;

    logic              r_valid;
    logic              r_sweep_request;
    logic              r_alert_active;
    logic              r_screen_dark;
    logic [15:0]       r_alert_count;
    logic [15:0]       r_sweep_count;
    logic [15:0]       r_alert_mhz;
    logic [7:0]        r_alert_margin;
    logic [22:0]       r_age_s;

    logic              take;
    logic [PROD_W-1:0] prod;
    logic [22:0]       n_age_s;

    assign o_stat_ready = !r_valid || o_rsp.ready;
    assign take         = i_stat_valid && o_stat_ready;

    assign prod    = PROD_W'(i_stat.age_ms) * PROD_W'(DIV1000_MAGIC);
    assign n_age_s = i_stat.age_en ? prod[PROD_W-1:DIV1000_SHIFT] : 23'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sweep_request <= i_stat.sweep_request;
            r_alert_active  <= i_stat.alert_active;
            r_screen_dark   <= i_stat.screen_dark;
            r_alert_count   <= i_stat.alert_count;
            r_sweep_count   <= i_stat.sweep_count;
            r_alert_mhz     <= i_stat.alert_mhz;
            r_alert_margin  <= i_stat.alert_margin_db;
            r_age_s         <= n_age_s;
        end
    end

    assign o_rsp.valid           = r_valid;
    assign o_rsp.sweep_request   = r_sweep_request;
    assign o_rsp.alert_active    = r_alert_active;
    assign o_rsp.screen_dark     = r_screen_dark;
    assign o_rsp.alert_count     = r_alert_count;
    assign o_rsp.sweep_count     = r_sweep_count;
    assign o_rsp.alert_mhz       = r_alert_mhz;
    assign o_rsp.alert_margin_db = r_alert_margin;
    assign o_rsp.alert_age_s     = r_age_s;

endmodule

// ===== hw/rtl/rf_activity_sentry_core.sv =====
// A request accepted by the state update stage is registered there, then passes
// through the seconds stage (one 32x29 multiply by the reciprocal of 1000) to the
// response. Throughput: one request per cycle while the response side is ready.
// Synchronous active-low reset: empties both stages, loads register defaults
// and starts the watch at time 0 with the screen lit until 5000 ms.
module rf_activity_sentry_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    rfas_req_if.sink    i_req,
    rfas_rsp_if.source  o_rsp
);
    import rfas_pkg::*;

    t_stat stat;
    logic  stat_valid;
    logic  stat_ready;

    rfas_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (i_req),
        .o_stat       (stat),
        .o_stat_valid (stat_valid),
        .i_stat_ready (stat_ready)
    );

    rfas_age u_age (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stat       (stat),
        .i_stat_valid (stat_valid),
        .o_stat_ready (stat_ready),
        .o_rsp        (o_rsp)
    );

endmodule

// ===== hw/rtl/rfas_checker.sv =====
module rfas_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_sweep_request,
    input logic        i_alert_active,
    input logic        i_screen_dark,
    input logic [15:0] i_alert_count,
    input logic [15:0] i_sweep_count,
    input logic [22:0] i_alert_age_s
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_alert_count)
            && $stable(i_sweep_count) && $stable(i_alert_age_s))
        else $error("stalled response changed");

    a_rsp_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(i_req_valid && i_req_ready, 2))
        else $error("response without request two cycles earlier");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && $past(i_rsp_valid && i_rsp_ready)
            |-> i_sweep_count >= $past(i_sweep_count)
                && i_alert_count >= $past(i_alert_count))
        else $error("counter went backward");

    a_alert_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_alert_active |-> i_alert_count != 16'd0 && !i_screen_dark)
        else $error("alert standing with no count or dark screen");

    a_sweep_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_sweep_request |-> i_sweep_count != 16'd0)
        else $error("sweep requested but not counted");

endmodule

bind rf_activity_sentry_core rfas_checker u_rfas_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_sweep_request (o_rsp.sweep_request),
    .i_alert_active  (o_rsp.alert_active),
    .i_screen_dark   (o_rsp.screen_dark),
    .i_alert_count   (o_rsp.alert_count),
    .i_sweep_count   (o_rsp.sweep_count),
    .i_alert_age_s   (o_rsp.alert_age_s)
);
